>>> hw/rtl/tkrl_pkg.sv
// tkrl_pkg: request/response types, action codes and defaults for the
// top-k and recent list unit. No dependencies.
`timescale 1ns / 1ps

package tkrl_pkg;

    // default sizing
    localparam int CAPACITY_DEF   = 16;
    localparam int SCORE_BITS_DEF = 32;

    // limit register reset value
    localparam logic [4:0] MAX_ENTRIES_RST = 5'd16;

    // action codes
    localparam logic [1:0] ACT_ADD         = 2'd0;
    localparam logic [1:0] ACT_READ_RANKED = 2'd1;
    localparam logic [1:0] ACT_READ_RECENT = 2'd2;

    // request payload
    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] score_value;
        logic [31:0]        entry_tag;
        logic [3:0]         read_index;
    } t_req;

    // response payload
    typedef struct packed {
        logic signed [31:0] out_score;
        logic [31:0]        out_tag;
        logic               out_valid;
        logic [4:0]         ranked_count;
        logic [4:0]         recent_count;
    } t_rsp;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic run;
    } t_dp_cmd;

endpackage

>>> hw/rtl/tkrl_ctrl.sv
// tkrl_ctrl: request sequencer for the list unit (accept, execute, respond).
// Depends on tkrl_pkg.
`timescale 1ns / 1ps

module tkrl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_strobe,
    output tkrl_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_strobe <= 1'b0;
                    if (start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state  <= S_DONE;
                    r_strobe <= 1'b1;
                end
                S_DONE: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b0;
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b0;
                end
            endcase
        end
    end

    // datapath commands
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.run  = (r_state == S_EXEC);

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

endmodule

>>> hw/rtl/tkrl_dp.sv
// tkrl_dp: entry cell rows for the ranked and recent lists, fill counts,
// limit register and response registers. Depends on tkrl_pkg.
`timescale 1ns / 1ps

module tkrl_dp #(
    parameter int CAPACITY   = tkrl_pkg::CAPACITY_DEF,
    parameter int SCORE_BITS = tkrl_pkg::SCORE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tkrl_pkg::t_dp_cmd i_cmd,
    input  tkrl_pkg::t_req    i_req,
    input  logic              i_cfg_we,
    input  logic [4:0]        i_cfg_wdata,
    output tkrl_pkg::t_rsp    o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CW > 5) ? CW : 5;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    tkrl_pkg::t_req               r_req;
    logic signed [SCORE_BITS-1:0] r_rk_score [CAPACITY];
    logic [31:0]                  r_rk_tag   [CAPACITY];
    logic signed [SCORE_BITS-1:0] r_rc_score [CAPACITY];
    logic [31:0]                  r_rc_tag   [CAPACITY];
    logic [CW-1:0]                r_rk_fill;
    logic [CW-1:0]                r_rc_fill;
    logic [4:0]                   r_max;
    logic signed [31:0]           r_out_score;
    logic [31:0]                  r_out_tag;
    logic                         r_out_valid;

    logic signed [SCORE_BITS-1:0] n_rk_score [CAPACITY];
    logic [31:0]                  n_rk_tag   [CAPACITY];
    logic signed [SCORE_BITS-1:0] n_rc_score [CAPACITY];
    logic [31:0]                  n_rc_tag   [CAPACITY];
    logic [CW-1:0]                n_rk_fill;
    logic [CW-1:0]                n_rc_fill;
    logic signed [31:0]           n_out_score;
    logic [31:0]                  n_out_tag;
    logic                         n_out_valid;

    logic signed [SCORE_BITS-1:0] new_score;
    logic [CAPACITY-1:0]          keep;
    logic [AW-1:0]                lim;
    logic [AW-1:0]                rk_inc;
    logic [AW-1:0]                rc_inc;
    logic [AW-1:0]                rd_idx;
    logic [IW-1:0]                rd_sel;
    logic                         rk_hit;
    logic                         rc_hit;

    // score wrap, limit and next counts
    always_comb begin
        new_score = SCORE_BITS'(r_req.score_value);
        lim       = (AW'(r_max) < AW'(CAPACITY)) ? AW'(r_max) : AW'(CAPACITY);
        rk_inc    = AW'(r_rk_fill) + AW'(1);
        rc_inc    = AW'(r_rc_fill) + AW'(1);
        n_rk_fill = CW'((rk_inc < lim) ? rk_inc : lim);
        n_rc_fill = CW'((rc_inc < lim) ? rc_inc : lim);
    end

    // ranked row: a cell keeps its entry if it is held and scores at least the new one
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            keep[i] = (CW'(i) < r_rk_fill) && (r_rk_score[i] >= new_score);
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (keep[i]) begin
                n_rk_score[i] = r_rk_score[i];
                n_rk_tag[i]   = r_rk_tag[i];
            end else if (i == 0) begin
                n_rk_score[i] = new_score;
                n_rk_tag[i]   = r_req.entry_tag;
            end else if (keep[(i == 0) ? 0 : i - 1]) begin
                n_rk_score[i] = new_score;
                n_rk_tag[i]   = r_req.entry_tag;
            end else begin
                n_rk_score[i] = r_rk_score[(i == 0) ? 0 : i - 1];
                n_rk_tag[i]   = r_rk_tag[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // recent row: shift everything back, new entry at the front
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == 0) begin
                n_rc_score[i] = new_score;
                n_rc_tag[i]   = r_req.entry_tag;
            end else begin
                n_rc_score[i] = r_rc_score[(i == 0) ? 0 : i - 1];
                n_rc_tag[i]   = r_rc_tag[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // indexed read of either list
    always_comb begin
        rd_idx      = AW'(r_req.read_index);
        rd_sel      = rd_idx[IW-1:0];
        rk_hit      = (rd_idx < AW'(r_rk_fill)) && (rd_idx < AW'(CAPACITY));
        rc_hit      = (rd_idx < AW'(r_rc_fill)) && (rd_idx < AW'(CAPACITY));
        n_out_score = '0;
        n_out_tag   = '0;
        n_out_valid = 1'b0;
        unique case (r_req.action)
            tkrl_pkg::ACT_READ_RANKED: begin
                if (rk_hit) begin
                    n_out_score = 32'(r_rk_score[rd_sel]);
                    n_out_tag   = r_rk_tag[rd_sel];
                    n_out_valid = 1'b1;
                end
            end
            tkrl_pkg::ACT_READ_RECENT: begin
                if (rc_hit) begin
                    n_out_score = 32'(r_rc_score[rd_sel]);
                    n_out_tag   = r_rc_tag[rd_sel];
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // control state: counts and limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rk_fill <= '0;
            r_rc_fill <= '0;
            r_max     <= tkrl_pkg::MAX_ENTRIES_RST;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (i_cmd.run && (r_req.action == tkrl_pkg::ACT_ADD)) begin
                r_rk_fill <= n_rk_fill;
                r_rc_fill <= n_rc_fill;
            end
        end
    end

    // payload: captured request, entry cells, response
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.run) begin
            r_out_score <= n_out_score;
            r_out_tag   <= n_out_tag;
            r_out_valid <= n_out_valid;
            if (r_req.action == tkrl_pkg::ACT_ADD) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    r_rk_score[i] <= n_rk_score[i];
                    r_rk_tag[i]   <= n_rk_tag[i];
                    r_rc_score[i] <= n_rc_score[i];
                    r_rc_tag[i]   <= n_rc_tag[i];
                end
            end
        end
    end

    assign o_rsp.out_score    = r_out_score;
    assign o_rsp.out_tag      = r_out_tag;
    assign o_rsp.out_valid    = r_out_valid;
    assign o_rsp.ranked_count = 5'(r_rk_fill);
    assign o_rsp.recent_count = 5'(r_rc_fill);

endmodule

>>> hw/rtl/top_k_and_recent_list_unit.sv
// top_k_and_recent_list_unit: top level of the ranked and recent list unit.
// Depends on tkrl_pkg, tkrl_ctrl and tkrl_dp.
`timescale 1ns / 1ps

//  channel    signals                        direction  handshake
//  request    start, busy, i_req             in         start && !busy
//  response   o_strobe, o_rsp                out        o_strobe, one cycle
//  config     i_cfg_we, i_cfg_wdata          in         i_cfg_we
//
//  each request is handled in order: accept, a pass through the
//  compare-and-shift cell rows (or the indexed read), then the strobe;
//  busy drops after the strobe, so no new request is accepted until the
//  last is answered. reset clears both counts and sets the limit to 16;
//  the entry cells are not cleared. the receiver cannot stall the response.

module top_k_and_recent_list_unit #(
    parameter int CAPACITY   = tkrl_pkg::CAPACITY_DEF,
    parameter int SCORE_BITS = tkrl_pkg::SCORE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tkrl_pkg::t_req i_req,
    output logic           o_strobe,
    output tkrl_pkg::t_rsp o_rsp,
    input  logic           i_cfg_we,
    input  logic [4:0]     i_cfg_wdata
);

    tkrl_pkg::t_dp_cmd cmd;

    // sequencer
    tkrl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    // list datapath
    tkrl_dp #(
        .CAPACITY   (CAPACITY),
        .SCORE_BITS (SCORE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    // a response only comes while a request is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("response strobe without a request in flight");

    // an accepted request holds off the next one
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // every accepted request gets its response strobe after the execute state
    a_accept_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("response missing after accepted request");
`endif

endmodule
